// ----- src/erl_pkg.sv -----
// ----------------------------------------------------------------------------
// erl_pkg
// Shared widths, types and constants for the ellipse ray intersection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package erl_pkg;

  localparam int ANGLE_BITS    = 16;
  localparam int COORD_BITS    = 24;
  localparam int CORDIC_STAGES = 16;

  localparam int PHASE_W = 32;
  localparam int DIR_W   = 31;
  localparam int MAG_W   = COORD_BITS + DIR_W;
  localparam int NORM_W  = 31;
  localparam int SH_W    = $clog2(MAG_W - NORM_W + 1);
  localparam int SQ_W    = 2 * NORM_W + 1;
  localparam int ROOT_W  = 32;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int REM_W   = ROOT_W + 3;
  localparam int NUM_W   = COORD_BITS + NORM_W + 1;
  localparam int QUO_W   = COORD_BITS + 1;
  localparam int OUT_W   = COORD_BITS + 1;
  localparam int SUM_W   = COORD_BITS + 2;

  localparam logic signed [PHASE_W-1:0] X_INIT = PHASE_W'(1) << (PHASE_W - 3);

  // arctan(2^-i), 2^32 per full turn
  localparam logic [PHASE_W-1:0] ATAN_TAB [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef enum logic [1:0] {
    CFG_SEMI_X   = 2'd0,
    CFG_SEMI_Y   = 2'd1,
    CFG_CENTRE_X = 2'd2,
    CFG_CENTRE_Y = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [DIR_W-1:0] c_abs;
    logic [DIR_W-1:0] s_abs;
    logic             c_neg;
    logic             s_neg;
  } dir_t;

  typedef struct packed {
    logic [NORM_W-1:0] p;
    logic [NORM_W-1:0] q;
    logic [SQ_W-1:0]   sum;
    logic              c_neg;
    logic              s_neg;
  } mag_t;

  typedef struct packed {
    logic [NORM_W-1:0] p;
    logic [NORM_W-1:0] q;
    logic [ROOT_W-1:0] r;
    logic              c_neg;
    logic              s_neg;
  } root_t;

endpackage

`default_nettype wire

// ----- src/erl_cordic.sv -----
// ----------------------------------------------------------------------------
// erl_cordic
// Rotation-mode cordic, one iteration per stage, then quadrant fold and abs.
// ----------------------------------------------------------------------------
`default_nettype none

module erl_cordic import erl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [ANGLE_BITS-1:0] angle_i,
  output logic                  valid_o,
  output dir_t                  dir_o
);

  logic [PHASE_W-1:0] phase;
  assign phase = {angle_i, {(PHASE_W - ANGLE_BITS){1'b0}}};

  logic signed [PHASE_W-1:0] x_q [CORDIC_STAGES+1];
  logic signed [PHASE_W-1:0] y_q [CORDIC_STAGES+1];
  logic signed [PHASE_W-1:0] z_q [CORDIC_STAGES+1];
  logic [1:0]                quad_q [CORDIC_STAGES+1];
  logic                      axis_q [CORDIC_STAGES+1];
  logic                      vld_q  [CORDIC_STAGES+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= X_INIT;
      y_q[0]    <= '0;
      z_q[0]    <= {2'b00, phase[PHASE_W-3:0]};
      quad_q[0] <= phase[PHASE_W-1:PHASE_W-2];
      axis_q[0] <= (phase[PHASE_W-3:0] == '0);
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
    logic signed [PHASE_W-1:0] dx, dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][PHASE_W-1]) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - $signed(ATAN_TAB[i]);
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + $signed(ATAN_TAB[i]);
        end
        quad_q[i+1] <= quad_q[i];
        axis_q[i+1] <= axis_q[i];
      end
    end
  end

  logic signed [PHASE_W-1:0] cx, sy, c, s, c_mag, s_mag;
  dir_t dir_d, dir_q;
  logic valid_q;

  always_comb begin
    // exact axis direction when the residual angle is zero
    cx = axis_q[CORDIC_STAGES] ? X_INIT : x_q[CORDIC_STAGES];
    sy = axis_q[CORDIC_STAGES] ? '0 : y_q[CORDIC_STAGES];
    unique case (quad_q[CORDIC_STAGES])
      2'd1:    begin c = -sy; s = cx;  end
      2'd2:    begin c = -cx; s = -sy; end
      2'd3:    begin c = sy;  s = -cx; end
      default: begin c = cx;  s = sy;  end
    endcase
    c_mag = c[PHASE_W-1] ? -c : c;
    s_mag = s[PHASE_W-1] ? -s : s;
    dir_d.c_abs = c_mag[DIR_W-1:0];
    dir_d.s_abs = s_mag[DIR_W-1:0];
    dir_d.c_neg = c[PHASE_W-1];
    dir_d.s_neg = s[PHASE_W-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= vld_q[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dir_q <= dir_d;
    end
  end

  assign valid_o = valid_q;
  assign dir_o   = dir_q;

endmodule

`default_nettype wire

// ----- src/erl_norm.sv -----
// ----------------------------------------------------------------------------
// erl_norm
// Scales the direction by the semi-axes, normalizes both to 31 bits and
// forms the sum of squares.
// ----------------------------------------------------------------------------
`default_nettype none

module erl_norm import erl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic [COORD_BITS-1:0] semi_x_i,
  input  logic [COORD_BITS-1:0] semi_y_i,
  input  logic                  valid_i,
  input  dir_t                  dir_i,
  output logic                  valid_o,
  output mag_t                  mag_o
);

  logic [4:0] vld_q;

  logic [MAG_W-1:0]  p1_q, q1_q, p2_q, q2_q;
  logic [SH_W-1:0]   sh_d, sh_q;
  logic [NORM_W-1:0] p3_q, q3_q, p4_q, q4_q;
  logic [2*NORM_W-1:0] pp_q, qq_q;
  logic [SQ_W-1:0]   sum_q;
  logic [1:0]        sg1_q, sg2_q, sg3_q, sg4_q, sg5_q;
  logic [MAG_W-1:0]  m, p_shr, q_shr;
  logic [NORM_W-1:0] mag_o_p_q, mag_o_q_q;

  always_comb begin
    m    = p1_q | q1_q;
    sh_d = '0;
    for (int k = 0; k < MAG_W - NORM_W; k++) begin
      if (m[NORM_W + k]) sh_d = SH_W'(k + 1);
    end
  end

  assign p_shr = p2_q >> sh_q;
  assign q_shr = q2_q >> sh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q  <= MAG_W'(semi_y_i) * MAG_W'(dir_i.c_abs);
      q1_q  <= MAG_W'(semi_x_i) * MAG_W'(dir_i.s_abs);
      sg1_q <= {dir_i.c_neg, dir_i.s_neg};
      p2_q  <= p1_q;
      q2_q  <= q1_q;
      sh_q  <= sh_d;
      sg2_q <= sg1_q;
      p3_q  <= p_shr[NORM_W-1:0];
      q3_q  <= q_shr[NORM_W-1:0];
      sg3_q <= sg2_q;
      pp_q  <= (2*NORM_W)'(p3_q) * (2*NORM_W)'(p3_q);
      qq_q  <= (2*NORM_W)'(q3_q) * (2*NORM_W)'(q3_q);
      p4_q  <= p3_q;
      q4_q  <= q3_q;
      sg4_q <= sg3_q;
      sum_q <= SQ_W'(pp_q) + SQ_W'(qq_q);
      mag_o_p_q <= p4_q;
      mag_o_q_q <= q4_q;
      sg5_q <= sg4_q;
    end
  end

  assign valid_o     = vld_q[4];
  assign mag_o.p     = mag_o_p_q;
  assign mag_o.q     = mag_o_q_q;
  assign mag_o.sum   = sum_q;
  assign mag_o.c_neg = sg5_q[1];
  assign mag_o.s_neg = sg5_q[0];

endmodule

`default_nettype wire

// ----- src/erl_sqrt.sv -----
// ----------------------------------------------------------------------------
// erl_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module erl_sqrt import erl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  mag_t  mag_i,
  output logic  valid_o,
  output root_t root_o
);

  logic [REM_W-1:0]  rem_q  [ROOT_W+1];
  logic [ROOT_W-1:0] root_q [ROOT_W+1];
  logic [RAD_W-1:0]  v_q    [ROOT_W+1];
  root_t             side_q [ROOT_W+1];
  logic              vld_q  [ROOT_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]        <= '0;
      root_q[0]       <= '0;
      v_q[0]          <= RAD_W'(mag_i.sum);
      side_q[0].p     <= mag_i.p;
      side_q[0].q     <= mag_i.q;
      side_q[0].r     <= '0;
      side_q[0].c_neg <= mag_i.c_neg;
      side_q[0].s_neg <= mag_i.s_neg;
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_bit
    logic [REM_W-1:0] rem2, trial;
    logic             ge;
    assign rem2  = {rem_q[k][REM_W-3:0], v_q[k][RAD_W-1 -: 2]};
    assign trial = REM_W'({root_q[k], 2'b01});
    assign ge    = (rem2 >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= ge ? rem2 - trial : rem2;
        root_q[k+1] <= {root_q[k][ROOT_W-2:0], ge};
        v_q[k+1]    <= v_q[k] << 2;
        side_q[k+1] <= side_q[k];
      end
    end
  end

  always_comb begin
    root_o   = side_q[ROOT_W];
    root_o.r = root_q[ROOT_W];
  end
  assign valid_o = vld_q[ROOT_W];

endmodule

`default_nettype wire

// ----- src/erl_div.sv -----
// ----------------------------------------------------------------------------
// erl_div
// Pipelined restoring divider, one quotient bit per stage, carries a sign.
// ----------------------------------------------------------------------------
`default_nettype none

module erl_div import erl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [ROOT_W-1:0] den_i,
  input  logic              neg_i,
  output logic              valid_o,
  output logic [QUO_W-1:0]  quo_o,
  output logic              neg_o
);

  logic [ROOT_W-1:0] rem_q  [QUO_W+1];
  logic [QUO_W-1:0]  low_q  [QUO_W+1];
  logic [QUO_W-1:0]  quo_q  [QUO_W+1];
  logic [ROOT_W-1:0] den_q  [QUO_W+1];
  logic              zero_q [QUO_W+1];
  logic              neg_q  [QUO_W+1];
  logic              vld_q  [QUO_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= ROOT_W'(num_i[NUM_W-1:QUO_W]);
      low_q[0]  <= num_i[QUO_W-1:0];
      quo_q[0]  <= '0;
      den_q[0]  <= den_i;
      zero_q[0] <= (den_i == '0);
      neg_q[0]  <= neg_i;
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_bit
    logic [ROOT_W:0] r2, diff;
    logic            ge;
    assign r2   = {rem_q[k], low_q[k][QUO_W-1]};
    assign diff = r2 - {1'b0, den_q[k]};
    assign ge   = (r2 >= {1'b0, den_q[k]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= ge ? diff[ROOT_W-1:0] : r2[ROOT_W-1:0];
        low_q[k+1]  <= low_q[k] << 1;
        quo_q[k+1]  <= {quo_q[k][QUO_W-2:0], ge};
        den_q[k+1]  <= den_q[k];
        zero_q[k+1] <= zero_q[k];
        neg_q[k+1]  <= neg_q[k];
      end
    end
  end

  // a zero radius gives a zero offset
  assign quo_o   = zero_q[QUO_W] ? '0 : quo_q[QUO_W];
  assign neg_o   = neg_q[QUO_W];
  assign valid_o = vld_q[QUO_W];

endmodule

`default_nettype wire

// ----- src/ellipse_ray_intersection.sv -----
// ----------------------------------------------------------------------------
// ellipse_ray_intersection
// Point where a ray from the centre of an axis-aligned ellipse meets it.
// ----------------------------------------------------------------------------
// Fully pipelined: one item accepted per clock unless the output stalls
// (18 cordic stages, 5 scale/normalize/square stages, 33 square root stages,
// 1 numerator stage, 26 divider stages, 1 output stage). The square root and
// the two dividers resolve one bit per stage, which sets the depth. The whole
// pipeline holds while a result waits on the output. Configuration registers
// are read directly by the pipeline and must only be written while idle.
`default_nettype none

module ellipse_ray_intersection import erl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [ANGLE_BITS-1:0] ray_angle_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_W-1:0]      point_x_o,
  output logic [OUT_W-1:0]      point_y_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  cfg_reg_e              cfg_index_i,
  input  logic [COORD_BITS-1:0] cfg_data_i
);

  logic [COORD_BITS-1:0] semi_x_q, semi_y_q, centre_x_q, centre_y_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      semi_x_q   <= COORD_BITS'(256);
      semi_y_q   <= COORD_BITS'(256);
      centre_x_q <= '0;
      centre_y_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SEMI_X:   semi_x_q   <= cfg_data_i;
        CFG_SEMI_Y:   semi_y_q   <= cfg_data_i;
        CFG_CENTRE_X: centre_x_q <= cfg_data_i;
        CFG_CENTRE_Y: centre_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic pipe_en, out_valid_q;
  assign pipe_en    = !out_valid_q || out_ready_i;
  assign in_ready_o = pipe_en;

  logic  dir_v, mag_v, root_v;
  dir_t  dir;
  mag_t  mag;
  root_t root;

  erl_cordic u_cordic (
    .clk_i, .rst_ni, .en_i(pipe_en), .valid_i(in_valid_i), .angle_i(ray_angle_i),
    .valid_o(dir_v), .dir_o(dir)
  );

  erl_norm u_norm (
    .clk_i, .rst_ni, .en_i(pipe_en), .semi_x_i(semi_x_q), .semi_y_i(semi_y_q),
    .valid_i(dir_v), .dir_i(dir), .valid_o(mag_v), .mag_o(mag)
  );

  erl_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i(pipe_en), .valid_i(mag_v), .mag_i(mag),
    .valid_o(root_v), .root_o(root)
  );

  // rounded numerators for both offsets
  logic [NUM_W-1:0]  numx_q, numy_q;
  logic [ROOT_W-1:0] den_q;
  logic              cneg_q, sneg_q, num_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_v_q <= 1'b0;
    end else if (pipe_en) begin
      num_v_q <= root_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      numx_q <= NUM_W'(NUM_W'(semi_x_q) * NUM_W'(root.p)) + NUM_W'(root.r >> 1);
      numy_q <= NUM_W'(NUM_W'(semi_y_q) * NUM_W'(root.q)) + NUM_W'(root.r >> 1);
      den_q  <= root.r;
      cneg_q <= root.c_neg;
      sneg_q <= root.s_neg;
    end
  end

  logic             divx_v, divy_v, negx, negy;
  logic [QUO_W-1:0] quox, quoy;

  erl_div u_div_x (
    .clk_i, .rst_ni, .en_i(pipe_en), .valid_i(num_v_q), .num_i(numx_q),
    .den_i(den_q), .neg_i(cneg_q), .valid_o(divx_v), .quo_o(quox), .neg_o(negx)
  );

  erl_div u_div_y (
    .clk_i, .rst_ni, .en_i(pipe_en), .valid_i(num_v_q), .num_i(numy_q),
    .den_i(den_q), .neg_i(sneg_q), .valid_o(divy_v), .quo_o(quoy), .neg_o(negy)
  );

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 << COORD_BITS) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(1 << COORD_BITS);

  logic signed [SUM_W-1:0] offx, offy, sumx, sumy;
  logic [OUT_W-1:0]        px_d, py_d, px_q, py_q;

  always_comb begin
    offx = negx ? -$signed(SUM_W'(quox)) : $signed(SUM_W'(quox));
    offy = negy ? -$signed(SUM_W'(quoy)) : $signed(SUM_W'(quoy));
    sumx = $signed({{2{centre_x_q[COORD_BITS-1]}}, centre_x_q}) + offx;
    sumy = $signed({{2{centre_y_q[COORD_BITS-1]}}, centre_y_q}) + offy;
    if (sumx > SAT_HI)      px_d = SAT_HI[OUT_W-1:0];
    else if (sumx < SAT_LO) px_d = SAT_LO[OUT_W-1:0];
    else                    px_d = sumx[OUT_W-1:0];
    if (sumy > SAT_HI)      py_d = SAT_HI[OUT_W-1:0];
    else if (sumy < SAT_LO) py_d = SAT_LO[OUT_W-1:0];
    else                    py_d = sumy[OUT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      out_valid_q <= divx_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      px_q <= px_d;
      py_q <= py_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign point_x_o   = px_q;
  assign point_y_o   = py_q;

  // the root of p^2 + q^2 never falls below either term
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_v |-> (root.r >= ROOT_W'(root.p)) && (root.r >= ROOT_W'(root.q)))
    else $error("square root below its operand");

  // both dividers run in lockstep
  assert property (@(posedge clk_i) disable iff (!rst_ni) divx_v == divy_v)
    else $error("divider lanes out of step");

  // the offset never exceeds the semi-axis range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    divx_v |-> !quox[QUO_W-1] && !quoy[QUO_W-1])
    else $error("offset beyond semi-axis range");

  // a stall freezes the divider outputs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable(divx_v) && $stable(quox) && $stable(quoy))
    else $error("item changed during stall");

endmodule

`default_nettype wire

// ----- bench/ellipse_ray_intersection_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ellipse_ray_intersection_test
// Drives ray angles through the ellipse intersection pipeline under several
// ellipse settings and checks each point against a cycle-free predictor.
// ----------------------------------------------------------------------------

module ellipse_ray_intersection_test;
  import erl_pkg::*;

  localparam int LATENCY = 84;
  localparam int DEPTH   = 4096;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [ANGLE_BITS-1:0] ray_angle_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [OUT_W-1:0]      point_x_o;
  logic [OUT_W-1:0]      point_y_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  cfg_reg_e              cfg_index_i = CFG_SEMI_X;
  logic [COORD_BITS-1:0] cfg_data_i = '0;

  ellipse_ray_intersection dut (.*);

  always #5 clk_i = ~clk_i;

  // predictor copy of the ellipse registers
  logic [COORD_BITS-1:0] axis_a, axis_b, ctr_x, ctr_y;
  // expected points, written at accept and read in order at the result side
  logic [OUT_W-1:0] want_x_mem [DEPTH];
  logic [OUT_W-1:0] want_y_mem [DEPTH];
  int  wr_ptr   = 0;
  int  rd_ptr   = 0;
  int  n_errors = 0;
  int  n_points = 0;
  int  n_sent   = 0;
  bit  quiet    = 1'b0;  // no idling on either side

  localparam logic [31:0] ARCTAN [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  function automatic int pending();
    return wr_ptr - rd_ptr;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic logic [OUT_W-1:0] clamp_coord(longint v);
    longint hi;
    hi = (longint'(1) << COORD_BITS) - 1;
    if (v > hi) v = hi;
    if (v < -hi - 1) v = -hi - 1;
    return OUT_W'(v);
  endfunction

  task automatic predict_point(input logic [ANGLE_BITS-1:0] ang);
    logic [31:0] phase;
    logic [1:0]  quad;
    longint z, cx, sy, dx, dy, c, s, ox, oy;
    longint unsigned a, b, p, q, r, m;
    int sh;
    phase = {ang, {(32 - ANGLE_BITS){1'b0}}};
    quad  = phase[31:30];
    z  = longint'(phase[29:0]);
    cx = longint'(1) << 29;
    sy = 0;
    a  = axis_a;
    b  = axis_b;
    if (z != 0) begin
      for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
        dx = sy >>> i;
        dy = cx >>> i;
        if (z >= 0) begin
          cx -= dx; sy += dy; z -= longint'(ARCTAN[i]);
        end else begin
          cx += dx; sy -= dy; z += longint'(ARCTAN[i]);
        end
      end
    end
    case (quad)
      2'd1: begin c = -sy; s = cx; end
      2'd2: begin c = -cx; s = -sy; end
      2'd3: begin c = sy; s = -cx; end
      default: begin c = cx; s = sy; end
    endcase
    p = b * longint'(c < 0 ? -c : c);
    q = a * longint'(s < 0 ? -s : s);
    m = (p > q) ? p : q;
    sh = 0;
    while ((m >> sh) >= (64'd1 << 31)) sh++;
    p >>= sh;
    q >>= sh;
    r = int_sqrt(p * p + q * q);
    ox = 0;
    oy = 0;
    if (r != 0) begin
      ox = longint'((a * p + (r >> 1)) / r);
      oy = longint'((b * q + (r >> 1)) / r);
    end
    want_x_mem[wr_ptr % DEPTH] = clamp_coord(longint'($signed(ctr_x)) + (c < 0 ? -ox : ox));
    want_y_mem[wr_ptr % DEPTH] = clamp_coord(longint'($signed(ctr_y)) + (s < 0 ? -oy : oy));
    wr_ptr++;
  endtask

  task automatic send_angle(input logic [ANGLE_BITS-1:0] ang);
    if (!quiet && $urandom_range(3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(13, 1)) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    ray_angle_i <= ang;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_point(ang);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [COORD_BITS-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_SEMI_X:   axis_a = val;
      CFG_SEMI_Y:   axis_b = val;
      CFG_CENTRE_X: ctr_x  = val;
      default:      ctr_y  = val;
    endcase
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending() != 0) @(negedge clk_i);
    repeat (LATENCY + 8) @(negedge clk_i);
  endtask

  task automatic set_ellipse(input logic [COORD_BITS-1:0] a, b, x0, y0);
    drain();
    write_reg(CFG_SEMI_X, a);
    write_reg(CFG_SEMI_Y, b);
    write_reg(CFG_CENTRE_X, x0);
    write_reg(CFG_CENTRE_Y, y0);
    cfg_valid_i <= 1'b0;
  endtask

  // result side: random stalls, compare with oldest expectation
  always @(negedge clk_i) begin
    if (!quiet && $urandom_range(5) == 0) begin
      out_ready_i <= 1'b0;
      repeat ($urandom_range(13, 1)) @(negedge clk_i);
    end
    out_ready_i <= 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_points++;
      if (pending() == 0) begin
        $display("%0t: unexpected point x=%h y=%h", $time, point_x_o, point_y_o);
        n_errors++;
      end else begin
        if (point_x_o !== want_x_mem[rd_ptr % DEPTH]) begin
          $display("%0t: point_x expected %h actual %h", $time,
                   want_x_mem[rd_ptr % DEPTH], point_x_o);
          n_errors++;
        end
        if (point_y_o !== want_y_mem[rd_ptr % DEPTH]) begin
          $display("%0t: point_y expected %h actual %h", $time,
                   want_y_mem[rd_ptr % DEPTH], point_y_o);
          n_errors++;
        end
        rd_ptr++;
      end
    end
  end

  task automatic test_axis_and_extremes();
    logic [ANGLE_BITS-1:0] ang [12] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
      16'h0001, 16'h3FFF, 16'h4001, 16'hFFFF, 16'h2000, 16'hA000, 16'h5555, 16'hAAAA};
    foreach (ang[i]) send_angle(ang[i]);
  endtask

  task automatic test_zero_axis();
    set_ellipse(24'd0, 24'd512, 24'h000100, 24'hFFFF00);
    send_angle(16'h1234);
    send_angle(16'h0000);
    set_ellipse(24'd512, 24'd0, 24'h000080, 24'h000040);
    send_angle(16'h9876);
    send_angle(16'h4000);
  endtask

  task automatic test_saturation();
    set_ellipse(24'hFFFFFF, 24'hFFFFFF, 24'h7FFFFF, 24'h800000);
    test_axis_and_extremes();
    set_ellipse(24'hFFFFFF, 24'h000001, 24'h800000, 24'h7FFFFF);
    test_axis_and_extremes();
  endtask

  task automatic test_random_angles(input int n);
    for (int i = 0; i < n; i++) send_angle(ANGLE_BITS'($urandom));
  endtask

  task automatic test_random_ellipses();
    for (int k = 0; k < 8; k++) begin
      set_ellipse(COORD_BITS'($urandom_range(2 ** 20) << $urandom_range(3)),
                  COORD_BITS'($urandom_range(2 ** 20)),
                  COORD_BITS'($urandom), COORD_BITS'($urandom));
      test_random_angles(110);
    end
  endtask

  initial begin
    axis_a = 24'd256;
    axis_b = 24'd256;
    ctr_x  = '0;
    ctr_y  = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_axis_and_extremes();
    test_zero_axis();
    test_saturation();
    set_ellipse(24'd1280, 24'd384, 24'h000000, 24'h000000);
    test_random_angles(60);
    test_random_ellipses();
    quiet = 1'b1;
    set_ellipse(24'd256, 24'd256, 24'd0, 24'd0);
    test_random_angles(100);
    drain();
    $display("sent %0d ray angles over 15 ellipse settings, checked %0d points",
             n_sent, n_points);
    if (n_errors == 0 && pending() == 0) begin
      $display("ellipse_ray_intersection_test passed");
    end else begin
      $display("ellipse_ray_intersection_test failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("ellipse_ray_intersection_test failed");
    $finish;
  end

endmodule
